/* rtl/core/refcounted_lookup_or_allocate_table_macros.svh */
// Assertion macros for the reference-counted lookup-or-allocate table
`ifndef REFCOUNTED_LOOKUP_OR_ALLOCATE_TABLE_MACROS_SVH
`define REFCOUNTED_LOOKUP_OR_ALLOCATE_TABLE_MACROS_SVH

// Check a property on every clock edge outside reset
`define RLAT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define RLAT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/rlat_pkg.sv */
// Types and constants shared by the lookup-or-allocate table modules
`timescale 1ns / 1ps

package rlat_pkg;

  localparam int unsigned DEFAULT_ENTRIES = 32;
  localparam int unsigned KeyW      = 32;
  localparam int unsigned PayloadW  = 16;
  localparam int unsigned CountW    = 8;
  localparam int unsigned EntryIdxW = 5;
  localparam int unsigned OutcomeW  = 2;

  localparam logic [CountW-1:0] LIMIT_RESET = 8'hFF;

  typedef enum logic [OutcomeW-1:0] {
    OUTCOME_HIT      = 2'd0,
    OUTCOME_NEW      = 2'd1,
    OUTCOME_OVERFLOW = 2'd2,
    OUTCOME_FULL     = 2'd3
  } outcome_e;

  typedef struct packed {
    logic        [KeyW-1:0]     handle_key;
    logic        [KeyW-1:0]     source_key;
    logic        [KeyW-1:0]     attach_key;
    logic signed [PayloadW-1:0] payload_id;
  } req_t;

  typedef struct packed {
    logic [EntryIdxW-1:0] entry_index;
    logic [OutcomeW-1:0]  outcome;
    logic [CountW-1:0]    new_count;
  } rsp_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit_hit;
    logic commit_alloc;
  } ctl_cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_end;
    logic out_free;
  } ctl_sts_t;

endpackage

/* rtl/core/rlat_datapath.sv */
// Datapath: entry memories, live bits, scan pipeline and result register
`timescale 1ns / 1ps

module rlat_datapath #(
  parameter int unsigned ENTRIES = rlat_pkg::DEFAULT_ENTRIES
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rlat_pkg::req_t            in_req_i,
  input  logic                      cfg_we_i,
  input  logic [rlat_pkg::CountW-1:0] cfg_wdata_i,
  input  rlat_pkg::ctl_cmd_t        cmd_i,
  output rlat_pkg::ctl_sts_t        sts_o,
  input  logic                      out_stall_i,
  output logic                      out_valid_o,
  output rlat_pkg::rsp_t            out_rsp_o
);
  import rlat_pkg::*;

  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam int unsigned ExtW = (IdxW > EntryIdxW) ? IdxW : EntryIdxW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

  req_t              key_mem [ENTRIES];
  logic [CountW-1:0] cnt_mem [ENTRIES];
  logic [ENTRIES-1:0] live_q;

  req_t              req_q;
  logic [IdxW-1:0]   scan_idx_q;
  logic              issue_done_q;
  logic              rd_valid_q;
  logic [IdxW-1:0]   rd_idx_q;
  logic              rd_live_q;
  req_t              rd_entry_q;
  logic [CountW-1:0] rd_cnt_q;
  logic              free_found_q;
  logic [IdxW-1:0]   free_idx_q;
  logic [CountW-1:0] limit_q;
  logic              out_valid_q;
  rsp_t              out_rsp_q;

  logic              key_match;
  logic              hit;
  logic              over;
  logic [CountW-1:0] cnt_inc;
  logic              out_free;
  logic              key_we;
  logic              cnt_we;
  logic [IdxW-1:0]   cnt_waddr;
  logic [CountW-1:0] cnt_wdata;
  logic [IdxW-1:0]   res_idx;
  logic [ExtW-1:0]   res_idx_ext;
  logic              load_res;
  rsp_t              rsp_d;

  assign key_match = (rd_entry_q.handle_key == req_q.handle_key) &&
                     (rd_entry_q.source_key == req_q.source_key) &&
                     (rd_entry_q.attach_key == req_q.attach_key);
  assign hit       = rd_valid_q && rd_live_q && key_match;
  assign over      = (rd_cnt_q >= limit_q);
  assign cnt_inc   = rd_cnt_q + CountW'(1);
  assign out_free  = !out_valid_q || !out_stall_i;

  assign sts_o.hit      = hit;
  assign sts_o.scan_end = rd_valid_q && (rd_idx_q == LastIdx) && !hit;
  assign sts_o.out_free = out_free;

  assign key_we    = cmd_i.commit_alloc && free_found_q;
  assign cnt_we    = key_we || (cmd_i.commit_hit && !over);
  assign cnt_waddr = key_we ? free_idx_q : rd_idx_q;
  assign cnt_wdata = key_we ? CountW'(1) : cnt_inc;

  assign res_idx     = cmd_i.commit_alloc ? free_idx_q : rd_idx_q;
  assign res_idx_ext = ExtW'(res_idx);
  assign load_res    = cmd_i.commit_hit || cmd_i.commit_alloc;

  always_comb begin
    rsp_d = '0;
    if (cmd_i.commit_hit) begin
      if (over) begin
        rsp_d.outcome = OUTCOME_OVERFLOW;
      end else begin
        rsp_d.entry_index = res_idx_ext[EntryIdxW-1:0];
        rsp_d.outcome     = OUTCOME_HIT;
        rsp_d.new_count   = cnt_inc;
      end
    end else if (free_found_q) begin
      rsp_d.entry_index = res_idx_ext[EntryIdxW-1:0];
      rsp_d.outcome     = OUTCOME_NEW;
      rsp_d.new_count   = CountW'(1);
    end else begin
      rsp_d.outcome = OUTCOME_FULL;
    end
  end

  // Entry memories
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[free_idx_q] <= req_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && !issue_done_q) begin
      rd_entry_q <= key_mem[scan_idx_q];
      rd_cnt_q   <= cnt_mem[scan_idx_q];
      rd_live_q  <= live_q[scan_idx_q];
      rd_idx_q   <= scan_idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_q <= in_req_i;
    end
    if (cmd_i.scan && rd_valid_q && !rd_live_q && !free_found_q) begin
      free_idx_q <= rd_idx_q;
    end
    if (load_res) begin
      out_rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q       <= '0;
      scan_idx_q   <= '0;
      issue_done_q <= 1'b0;
      rd_valid_q   <= 1'b0;
      free_found_q <= 1'b0;
      limit_q      <= LIMIT_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (key_we) begin
        live_q[free_idx_q] <= 1'b1;
      end
      if (cmd_i.start) begin
        scan_idx_q   <= '0;
        issue_done_q <= 1'b0;
        rd_valid_q   <= 1'b0;
        free_found_q <= 1'b0;
      end else if (cmd_i.scan) begin
        rd_valid_q <= !issue_done_q;
        if (!issue_done_q) begin
          if (scan_idx_q == LastIdx) begin
            issue_done_q <= 1'b1;
          end else begin
            scan_idx_q <= scan_idx_q + IdxW'(1);
          end
        end
        if (rd_valid_q && !rd_live_q) begin
          free_found_q <= 1'b1;
        end
      end
      if (load_res) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

/* rtl/core/rlat_ctrl.sv */
// Controller: request sequencing through scan and commit
`timescale 1ns / 1ps

module rlat_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rlat_pkg::ctl_sts_t  sts_i,
  output rlat_pkg::ctl_cmd_t  cmd_o
);
  import rlat_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_HIT   = 4'b0100,
    ST_ALLOC = 4'b1000
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.hit) begin
          state_d = ST_HIT;
        end else begin
          cmd_o.scan = 1'b1;
          if (sts_i.scan_end) begin
            state_d = ST_ALLOC;
          end
        end
      end
      ST_HIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit_hit = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_ALLOC: begin
        if (sts_i.out_free) begin
          cmd_o.commit_alloc = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

/* rtl/core/refcounted_lookup_or_allocate_table.sv */
// Top level of the reference-counted lookup-or-allocate table
// A hit ends the scan early. The table takes one request at a time; the scan of
// the entry memory reads one entry per cycle.
// Reset clears all live bits at once (every entry free) and sets the count limit to 255.
`timescale 1ns / 1ps

module refcounted_lookup_or_allocate_table #(
  parameter int unsigned ENTRIES = rlat_pkg::DEFAULT_ENTRIES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  rlat_pkg::req_t              in_req_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output rlat_pkg::rsp_t              out_rsp_o,
  input  logic                        cfg_we_i,
  input  logic [rlat_pkg::CountW-1:0] cfg_wdata_i
);
  import rlat_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  rlat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rlat_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

/* rtl/core/rlat_checker.sv */
// Port-level assertion checker for the lookup-or-allocate table and its bind
`timescale 1ns / 1ps
`include "refcounted_lookup_or_allocate_table_macros.svh"

module rlat_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input rlat_pkg::rsp_t out_rsp_o
);
  import rlat_pkg::*;

  logic fail_rsp;
  logic fail_zero;
  logic new_rsp;
  logic new_one;
  logic hit_rsp;
  logic hit_two;

  assign fail_rsp  = out_valid_o && (out_rsp_o.outcome == OUTCOME_OVERFLOW ||
                                     out_rsp_o.outcome == OUTCOME_FULL);
  assign fail_zero = (out_rsp_o.entry_index == '0) && (out_rsp_o.new_count == '0);
  assign new_rsp   = out_valid_o && (out_rsp_o.outcome == OUTCOME_NEW);
  assign new_one   = (out_rsp_o.new_count == CountW'(1));
  assign hit_rsp   = out_valid_o && (out_rsp_o.outcome == OUTCOME_HIT);
  assign hit_two   = (out_rsp_o.new_count != '0) && (out_rsp_o.new_count != CountW'(1));

  `RLAT_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "result dropped")
  `RLAT_ASSERT_ALWAYS(a_fail_zero, clk_i, fail_rsp |-> fail_zero, "failure fields nonzero")
  `RLAT_ASSERT_ALWAYS(a_new_one, clk_i, new_rsp |-> new_one, "new entry count is not one")
  `RLAT_ASSERT_ALWAYS(a_hit_count, clk_i, hit_rsp |-> hit_two, "hit count below two")

endmodule

bind refcounted_lookup_or_allocate_table rlat_checker u_rlat_checker (.*);
